// ===== rtl/core/utf8d_pkg.sv =====
// Types, constants and helpers shared by the UTF-8 stream decoder modules.
package utf8d_pkg;

  // Width of the running offset counters; the offset fields carry them at full width.
  localparam int unsigned OffsetBits = 32;
  // Width of the offset fields in the result beat.
  localparam int unsigned OffFieldW  = 32;
  localparam int unsigned CodeW      = 21;

  // Lead byte classification masks and patterns.
  localparam logic [7:0] AsciiMask  = 8'b1000_0000;
  localparam logic [7:0] Lead2Mask  = 8'b1110_0000;
  localparam logic [7:0] Lead2Pat   = 8'b1100_0000;
  localparam logic [7:0] Lead3Mask  = 8'b1111_0000;
  localparam logic [7:0] Lead3Pat   = 8'b1110_0000;
  localparam logic [7:0] Lead4Mask  = 8'b1111_1000;
  localparam logic [7:0] Lead4Pat   = 8'b1111_0000;
  localparam logic [CodeW-1:0] BmpMax = CodeW'(16'hFFFF);

  localparam logic [1:0] OneWord  = 2'd1;
  localparam logic [1:0] TwoWords = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } text_in_t;

  typedef struct packed {
    logic [CodeW-1:0]     char_code;
    logic [1:0]           utf16_words;
    logic [OffFieldW-1:0] byte_offset_after;
    logic [OffFieldW-1:0] utf16_offset_after;
    logic [OffFieldW-1:0] utf32_offset_after;
    logic                 truncated;
    logic                 invalid_lead;
    logic                 text_end;
  } char_out_t;

  // Per-byte outcome handed from the decoder to the offset counters.
  typedef struct packed {
    logic emit;
    logic two_words;
    logic text_end;
  } char_event_t;

endpackage

// ===== rtl/core/utf8d_decode.sv =====
// Combinational byte decoder: sequence tracking and character result for one byte.
module utf8d_decode (
  input  utf8d_pkg::text_in_t            beat_i,
  input  logic [1:0]                     pending_i,
  input  logic [utf8d_pkg::CodeW-1:0]    partial_i,
  output logic [1:0]                     pending_o,
  output logic [utf8d_pkg::CodeW-1:0]    partial_o,
  output utf8d_pkg::char_event_t         event_o,
  output logic [utf8d_pkg::CodeW-1:0]    code_o,
  output logic                           truncated_o,
  output logic                           invalid_o
);
  import utf8d_pkg::*;

  logic [7:0]       b;
  logic             last;
  logic [CodeW-1:0] joined;
  logic [1:0]       pend_dec;

  assign b        = beat_i.text_byte;
  assign last     = beat_i.last_byte;
  assign joined   = {partial_i[CodeW-7:0], b[5:0]};
  assign pend_dec = pending_i - 2'd1;

  always_comb begin
    pending_o   = pending_i;
    partial_o   = partial_i;
    code_o      = '0;
    truncated_o = 1'b0;
    invalid_o   = 1'b0;
    event_o     = '0;
    if (pending_i != 2'd0) begin
      // Continuation slot: take the low six bits, no checking.
      partial_o = joined;
      pending_o = pend_dec;
      if (pend_dec == 2'd0) begin
        event_o.emit = 1'b1;
        code_o       = joined;
      end else if (last) begin
        event_o.emit = 1'b1;
        truncated_o  = 1'b1;
      end
    end else if ((b & AsciiMask) == 8'd0) begin
      event_o.emit = 1'b1;
      code_o       = CodeW'(b);
    end else if ((b & Lead2Mask) == Lead2Pat || (b & Lead3Mask) == Lead3Pat ||
                 (b & Lead4Mask) == Lead4Pat) begin
      priority if ((b & Lead2Mask) == Lead2Pat) begin
        partial_o = CodeW'(b[4:0]);
        pending_o = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Pat) begin
        partial_o = CodeW'(b[3:0]);
        pending_o = 2'd2;
      end else begin
        partial_o = CodeW'(b[2:0]);
        pending_o = 2'd3;
      end
      if (last) begin
        event_o.emit = 1'b1;
        truncated_o  = 1'b1;
      end
    end else begin
      event_o.emit = 1'b1;
      invalid_o    = 1'b1;
    end

    event_o.two_words = code_o > BmpMax;
    event_o.text_end  = last;

    // The end of the text clears the sequence state for the next text.
    if (last) begin
      pending_o = 2'd0;
      partial_o = '0;
    end
  end

endmodule

// ===== rtl/core/utf8d_offsets.sv =====
// Saturating byte, UTF-16 word and character offset counters.
module utf8d_offsets (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  utf8d_pkg::char_event_t              event_i,
  output logic [utf8d_pkg::OffsetBits-1:0]    byte_after_o,
  output logic [utf8d_pkg::OffsetBits-1:0]    utf16_after_o,
  output logic [utf8d_pkg::OffsetBits-1:0]    char_after_o
);
  import utf8d_pkg::*;

  logic [OffsetBits-1:0] byte_q, byte_d;
  logic [OffsetBits-1:0] utf16_q, utf16_d;
  logic [OffsetBits-1:0] char_q, char_d;
  logic [OffsetBits:0]   byte_sum, utf16_sum, char_sum;
  logic [1:0]            words;

  assign words     = event_i.two_words ? TwoWords : OneWord;
  assign byte_sum  = {1'b0, byte_q} + (OffsetBits + 1)'(1);
  assign utf16_sum = {1'b0, utf16_q} + (OffsetBits + 1)'(words);
  assign char_sum  = {1'b0, char_q} + (OffsetBits + 1)'(1);

  // A carry out means the sum passed the top: hold at all ones.
  assign byte_after_o  = byte_sum[OffsetBits] ? '1 : byte_sum[OffsetBits-1:0];
  assign utf16_after_o = !event_i.emit ? utf16_q :
                         utf16_sum[OffsetBits] ? '1 : utf16_sum[OffsetBits-1:0];
  assign char_after_o  = !event_i.emit ? char_q :
                         char_sum[OffsetBits] ? '1 : char_sum[OffsetBits-1:0];

  always_comb begin
    byte_d  = byte_q;
    utf16_d = utf16_q;
    char_d  = char_q;
    if (step_i) begin
      if (event_i.text_end) begin
        byte_d  = '0;
        utf16_d = '0;
        char_d  = '0;
      end else begin
        byte_d  = byte_after_o;
        utf16_d = utf16_after_o;
        char_d  = char_after_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      utf16_q <= '0;
      char_q  <= '0;
    end else begin
      byte_q  <= byte_d;
      utf16_q <= utf16_d;
      char_q  <= char_d;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: input register, decode stage, result register.
//
// The block takes UTF-8 text one byte per input beat (text_byte, last_byte)
// and gives one result beat per finished character: code point, UTF-16
// word count and the running byte, UTF-16 and character offsets after it.
// Bytes in the middle of a multi-byte sequence give no result beat. The
// beat that carries last_byte always gives a result beat, flagged text_end,
// and afterwards all offsets and sequence state are cleared for the next
// text. Invalid lead bytes give code point 0 with invalid_lead set; a text
// that ends inside a sequence gives code point 0 with truncated set.
// Both channels use valid/ready. An input beat lands in an input register;
// when the result side can take it, the decoder and the offset counters
// work on it and the result is written to the output register. One byte is
// taken per cycle, sustained, as long as the receiver keeps out_ready_i
// high; the sequence state and the counters loop around the decode stage
// through their own registers.
// When the receiver stalls, the result register holds, the decode stage
// holds its byte, and in_ready_o drops once the input register is full.
// Reset clears the pipeline valid flags, the sequence state and the offsets.
module utf8_stream_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utf8d_pkg::text_in_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8d_pkg::char_out_t out_data_o
);
  import utf8d_pkg::*;

  // Input register.
  logic     in_valid_q, in_valid_d;
  text_in_t in_beat_q;

  // Sequence state.
  logic [1:0]       pending_q, pending_d;
  logic [CodeW-1:0] partial_q, partial_d;

  // Result register.
  logic      out_valid_q, out_valid_d;
  char_out_t out_beat_q, out_beat_d;

  logic        res_ready;
  logic        step;
  char_event_t ev;
  logic [CodeW-1:0]      code;
  logic                  trunc, invalid;
  logic [OffsetBits-1:0] byte_after, utf16_after, char_after;

  // The result register can take a new beat when it is empty or being drained.
  assign res_ready  = !out_valid_q || out_ready_i;
  // The decode stage consumes its byte whenever the result side can follow.
  assign step       = in_valid_q && res_ready;
  assign in_ready_o = !in_valid_q || res_ready;

  utf8d_decode u_decode (
    .beat_i      (in_beat_q),
    .pending_i   (pending_q),
    .partial_i   (partial_q),
    .pending_o   (pending_d),
    .partial_o   (partial_d),
    .event_o     (ev),
    .code_o      (code),
    .truncated_o (trunc),
    .invalid_o   (invalid)
  );

  utf8d_offsets u_offsets (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .event_i       (ev),
    .byte_after_o  (byte_after),
    .utf16_after_o (utf16_after),
    .char_after_o  (char_after)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_beat_d.char_code          = code;
    out_beat_d.utf16_words        = ev.two_words ? TwoWords : OneWord;
    out_beat_d.byte_offset_after  = OffFieldW'(byte_after);
    out_beat_d.utf16_offset_after = OffFieldW'(utf16_after);
    out_beat_d.utf32_offset_after = OffFieldW'(char_after);
    out_beat_d.truncated          = trunc;
    out_beat_d.invalid_lead       = invalid;
    out_beat_d.text_end           = ev.text_end;

    out_valid_d = out_valid_q && !out_ready_i;
    if (step && ev.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pending_q   <= 2'd0;
      partial_q   <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step) begin
        pending_q <= pending_d;
        partial_q <= partial_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_beat_q <= in_data_i;
    end
    if (step && ev.emit) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  // The UTF-16 word count follows the code point range.
  a_words_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.utf16_words == TwoWords) ==
                     (out_data_o.char_code > BmpMax)))
    else $error("utf16_words does not match char_code");

  // A truncated result only comes at the end of the text and carries code 0.
  a_trunc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.truncated) |->
      (out_data_o.text_end && out_data_o.char_code == '0 && !out_data_o.invalid_lead))
    else $error("truncated result without end of text");

  // An invalid lead always gives code point 0.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.invalid_lead) |-> (out_data_o.char_code == '0))
    else $error("invalid lead with nonzero code point");

  // After the last byte of a text the sequence state is empty.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_beat_q.last_byte) |=> (pending_q == 2'd0))
    else $error("sequence state not cleared at end of text");

  // The last byte of a text always produces a result beat.
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_beat_q.last_byte) |=> (out_valid_o && out_data_o.text_end))
    else $error("end of text gave no result");

endmodule
